@@ src/sgc_pkg.sv @@
// ----------------------------------------------------------------------------
// sgc_pkg
// Types and constants shared by the stranded gap clusterer modules.
// ----------------------------------------------------------------------------
package sgc_pkg;

  localparam logic [1:0] CMD_SITE  = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic KIND_CLUSTER = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

  localparam logic REG_GAP = 1'b0;
  localparam logic REG_MIN = 1'b1;

  localparam logic [19:0] GAP_RESET     = 20'd100;
  localparam logic [15:0] MIN_RESET     = 16'd100;
  localparam logic [19:0] MEMBERS_MAX   = 20'hFFFFF;
  localparam logic [47:0] SUM_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam int          DIV_BITS      = 52;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  chrom_id;
    logic [31:0] site_start;
    logic [31:0] site_end;
    logic        site_strand;
    logic [23:0] site_score;
    logic [12:0] bin_index;
  } sgc_in_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  out_chrom;
    logic        out_strand;
    logic [31:0] cluster_start;
    logic [31:0] cluster_end;
    logic [19:0] member_count;
    logic [31:0] mean_score;
    logic [31:0] bin_value;
    logic        last;
  } sgc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DECODE,
    ST_CLOSE,
    ST_HRD,
    ST_HWR,
    ST_DIV,
    ST_EMIT,
    ST_UPDATE,
    ST_BREAD,
    ST_BEMIT
  } sgc_state_t;

  typedef struct packed {
    logic clear_step;
    logic latch_item;
    logic hist_rd;
    logic hist_wr;
    logic div_start;
    logic load_out;
    logic load_bin;
    logic update;
    logic close_done;
    logic strand;
    logic last;
  } sgc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_close;
    logic open0;
    logic open1;
    logic emit_ok;
    logic emit1;
    logic div_done;
    logic out_busy;
  } sgc_sts_t;

endpackage

@@ src/sgc_ram.sv @@
// ----------------------------------------------------------------------------
// sgc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/sgc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgc_ctrl
// Sequencer for record, flush and histogram read transactions.
// ----------------------------------------------------------------------------
module sgc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        cmd,
  input  logic              site_strand,
  input  sgc_pkg::sgc_sts_t sts,
  output logic              in_ready,
  output sgc_pkg::sgc_cmd_t ctl
);

  sgc_pkg::sgc_state_t state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic       str_r, str_nxt;
  logic       last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgc_pkg::ST_CLEAR;
      cmd_r   <= sgc_pkg::CMD_SITE;
      str_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      str_r   <= str_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    str_nxt   = str_r;
    last_nxt  = last_r;
    case (state_r)
      sgc_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = sgc_pkg::ST_IDLE;
      end
      sgc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd;
          str_nxt   = site_strand;
          state_nxt = sgc_pkg::ST_DECODE;
        end
      end
      sgc_pkg::ST_DECODE: begin
        case (cmd_r)
          sgc_pkg::CMD_SITE: begin
            last_nxt  = 1'b1;
            state_nxt = sts.need_close ? sgc_pkg::ST_CLOSE : sgc_pkg::ST_UPDATE;
          end
          sgc_pkg::CMD_FLUSH: begin
            if (sts.open0) begin
              str_nxt   = 1'b0;
              last_nxt  = !sts.emit1;
              state_nxt = sgc_pkg::ST_CLOSE;
            end else if (sts.open1) begin
              str_nxt   = 1'b1;
              last_nxt  = 1'b1;
              state_nxt = sgc_pkg::ST_CLOSE;
            end else begin
              state_nxt = sgc_pkg::ST_IDLE;
            end
          end
          sgc_pkg::CMD_READ: state_nxt = sgc_pkg::ST_BREAD;
          default:           state_nxt = sgc_pkg::ST_IDLE;
        endcase
      end
      sgc_pkg::ST_CLOSE: state_nxt = sgc_pkg::ST_HRD;
      sgc_pkg::ST_HRD:   state_nxt = sgc_pkg::ST_HWR;
      sgc_pkg::ST_HWR: begin
        state_nxt = sts.emit_ok ? sgc_pkg::ST_DIV : sgc_pkg::ST_EMIT;
      end
      sgc_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = sgc_pkg::ST_EMIT;
      end
      sgc_pkg::ST_EMIT: begin
        if (!sts.emit_ok || !sts.out_busy) begin
          if (cmd_r == sgc_pkg::CMD_SITE) begin
            state_nxt = sgc_pkg::ST_UPDATE;
          end else if (!str_r && sts.open1) begin
            str_nxt   = 1'b1;
            last_nxt  = 1'b1;
            state_nxt = sgc_pkg::ST_CLOSE;
          end else begin
            state_nxt = sgc_pkg::ST_IDLE;
          end
        end
      end
      sgc_pkg::ST_UPDATE: state_nxt = sgc_pkg::ST_IDLE;
      sgc_pkg::ST_BREAD:  state_nxt = sgc_pkg::ST_BEMIT;
      sgc_pkg::ST_BEMIT: begin
        if (!sts.out_busy) state_nxt = sgc_pkg::ST_IDLE;
      end
      default: state_nxt = sgc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.strand = str_r;
    ctl.last   = last_r;
    in_ready   = 1'b0;
    case (state_r)
      sgc_pkg::ST_CLEAR: ctl.clear_step = 1'b1;
      sgc_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        ctl.latch_item = in_valid;
      end
      sgc_pkg::ST_HRD:  ctl.hist_rd = 1'b1;
      sgc_pkg::ST_HWR: begin
        ctl.hist_wr   = 1'b1;
        ctl.div_start = sts.emit_ok;
      end
      sgc_pkg::ST_EMIT: begin
        if (!sts.emit_ok || !sts.out_busy) begin
          ctl.load_out   = sts.emit_ok;
          ctl.close_done = 1'b1;
        end
      end
      sgc_pkg::ST_UPDATE: ctl.update = 1'b1;
      sgc_pkg::ST_BEMIT:  ctl.load_bin = !sts.out_busy;
      default: in_ready = 1'b0;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hist_wr |-> $past(ctl.hist_rd))
    else $error("histogram write without read");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ctl.clear_step)
    else $error("ready during clearing");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_out || ctl.load_bin) |-> !sts.out_busy)
    else $error("output overwritten");

endmodule

@@ src/sgc_dp.sv @@
// ----------------------------------------------------------------------------
// sgc_dp
// Per-strand cluster state, histogram, serial divider and output register.
// ----------------------------------------------------------------------------
module sgc_dp #(
  parameter int HIST_BINS  = 8192,
  parameter int CHROM_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sgc_pkg::sgc_in_t  in_data,
  input  logic [19:0]       gap,
  input  logic [15:0]       min_m,
  input  sgc_pkg::sgc_cmd_t ctl,
  output sgc_pkg::sgc_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output sgc_pkg::sgc_out_t out_data
);

  localparam int HB = $clog2(HIST_BINS);
  localparam int DIV_BITS_L = sgc_pkg::DIV_BITS;
  localparam logic [CHROM_BITS-1:0] CH_MASK = {CHROM_BITS{1'b1}};

  sgc_pkg::sgc_in_t item_r;
  logic             open_r [2];
  logic [CHROM_BITS-1:0] chrom_r [2];
  logic [31:0] prev_r [2];
  logic [31:0] first_r [2];
  logic [31:0] end_r [2];
  logic [19:0] mem_r [2];
  logic [47:0] sum_r [2];

  logic [HB-1:0] clr_r;
  logic          clr_done_r;
  logic          s;
  logic [CHROM_BITS-1:0] ichrom;
  logic [31:0]   start_dist;
  logic [19:0]   n;
  logic [HB-1:0] bin;
  logic          ram_we;
  logic [HB-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign s          = ctl.strand;
  assign ichrom     = CHROM_BITS'(item_r.chrom_id) & CH_MASK;
  assign start_dist = item_r.site_start - prev_r[item_r.site_strand];
  assign n          = mem_r[s];
  assign bin    = ({12'd0, n} >= 32'(HIST_BINS - 1)) ? HB'(HIST_BINS - 1) : HB'(n);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = bin;
    ram_wdata = ram_rdata + 32'd1;
    if (ctl.clear_step) begin
      ram_we    = 1'b1;
      ram_addr  = clr_r;
      ram_wdata = '0;
    end else if (ctl.hist_wr) begin
      ram_we = 1'b1;
    end else if (!ctl.hist_rd) begin
      ram_addr = HB'(item_r.bin_index);
    end
  end

  sgc_ram #(.WIDTH(32), .DEPTH(HIST_BINS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (ctl.clear_step) begin
      clr_r      <= clr_r + 1'b1;
      clr_done_r <= (clr_r == HB'(HIST_BINS - 1));
    end
  end

  // Restoring divider: quotient of sum*10 by n*256, i.e. (sum*10)>>8 over n.
  logic [DIV_BITS_L-1:0] q_r;
  logic [20:0] rem_r;
  logic [5:0]  cnt_r;
  logic        div_busy_r, div_done_r;
  logic [20:0] trial;
  logic [51:0] num;
  logic [20:0] rem_sh;

  assign num    = 52'((({4'd0, sum_r[s]} << 3) + ({4'd0, sum_r[s]} << 1)) >> 8);
  assign rem_sh = {rem_r[19:0], q_r[DIV_BITS_L-1]};
  assign trial  = rem_sh - {1'b0, n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (ctl.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && cnt_r == 6'(DIV_BITS_L - 1)) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      q_r   <= num;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (div_busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (!trial[20]) begin
        rem_r <= trial;
        q_r   <= {q_r[DIV_BITS_L-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[DIV_BITS_L-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r[0] <= 1'b0;
      open_r[1] <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        chrom_r[i] <= '0;
        prev_r[i]  <= '0;
        first_r[i] <= '0;
        end_r[i]   <= '0;
        mem_r[i]   <= '0;
        sum_r[i]   <= '0;
      end
    end else if (ctl.close_done) begin
      open_r[s] <= 1'b0;
    end else if (ctl.update) begin
      chrom_r[s] <= ichrom;
      prev_r[s]  <= item_r.site_start;
      end_r[s]   <= item_r.site_end;
      open_r[s]  <= 1'b1;
      if (!open_r[s]) begin
        first_r[s] <= item_r.site_start;
        mem_r[s]   <= 20'd1;
        sum_r[s]   <= {24'd0, item_r.site_score};
      end else begin
        if (mem_r[s] != sgc_pkg::MEMBERS_MAX) mem_r[s] <= mem_r[s] + 20'd1;
        sum_r[s] <= (sum_r[s] > sgc_pkg::SUM_MAX - {24'd0, item_r.site_score}) ?
                    sgc_pkg::SUM_MAX : sum_r[s] + {24'd0, item_r.site_score};
      end
    end
  end

  logic [31:0] mean;
  assign mean = (q_r[DIV_BITS_L-1:32] != '0) ? 32'hFFFF_FFFF : q_r[31:0];

  sgc_pkg::sgc_out_t out_nxt;

  always_comb begin
    out_nxt = '0;
    if (ctl.load_bin) begin
      out_nxt.kind      = sgc_pkg::KIND_BIN;
      out_nxt.bin_value = ({19'd0, item_r.bin_index} < 32'(HIST_BINS)) ? ram_rdata : 32'd0;
      out_nxt.last      = 1'b1;
    end else begin
      out_nxt.kind          = sgc_pkg::KIND_CLUSTER;
      out_nxt.out_chrom     = 10'(chrom_r[s]);
      out_nxt.out_strand    = s;
      out_nxt.cluster_start = first_r[s];
      out_nxt.cluster_end   = end_r[s];
      out_nxt.member_count  = n;
      out_nxt.mean_score    = (n == '0) ? 32'd0 : mean;
      out_nxt.last          = ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out || ctl.load_bin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out || ctl.load_bin) out_data <= out_nxt;
  end

  assign sts.clear_done = clr_done_r;
  assign sts.need_close = open_r[item_r.site_strand] &&
    ((ichrom != chrom_r[item_r.site_strand]) || (start_dist > {12'd0, gap}));
  assign sts.open0    = open_r[0];
  assign sts.open1    = open_r[1];
  assign sts.emit_ok  = (n >= {4'd0, min_m}) && (n != '0);
  assign sts.emit1    = open_r[1] && (mem_r[1] >= {4'd0, min_m}) && (mem_r[1] != '0);
  assign sts.div_done = div_done_r;
  assign sts.out_busy = out_valid && !out_ready;

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |=> div_busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done_r |-> !div_busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("pending result changed");

endmodule

@@ src/stranded_gap_clusterer.sv @@
// ----------------------------------------------------------------------------
// stranded_gap_clusterer
// Per-strand gap clustering of sorted site records with a size histogram.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A record that joins its cluster passes
// through the decode and update states; one that closes a cluster and meets the
// member minimum also waits on the 52-step serial divider that forms the mean
// score. A flush may close two clusters. After reset the histogram memory is
// cleared before the first transaction is accepted.
module stranded_gap_clusterer #(
  parameter int HIST_BINS  = 8192,
  parameter int CHROM_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgc_pkg::sgc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sgc_pkg::sgc_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [19:0] gap_r;
  logic [15:0] min_r;
  sgc_pkg::sgc_cmd_t ctl;
  sgc_pkg::sgc_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= sgc_pkg::GAP_RESET;
      min_r <= sgc_pkg::MIN_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 &&
                 paddr[2] == sgc_pkg::REG_GAP) begin
      gap_r <= pwdata[19:0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 &&
                 paddr[2] == sgc_pkg::REG_MIN) begin
      min_r <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        sgc_pkg::REG_GAP: prdata = {12'd0, gap_r};
        sgc_pkg::REG_MIN: prdata = {16'd0, min_r};
        default:          prdata = '0;
      endcase
    end
  end

  sgc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .cmd         (in_data.cmd),
    .site_strand (in_data.site_strand),
    .sts         (sts),
    .in_ready    (in_ready),
    .ctl         (ctl)
  );

  sgc_dp #(.HIST_BINS(HIST_BINS), .CHROM_BITS(CHROM_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .gap       (gap_r),
    .min_m     (min_r),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
